// ===== sv/rycc_pkg.sv =====
// rycc_pkg: word types, stage payload types and fixed-point constants
// for the rgb / ycbcr color converter; no dependencies
package rycc_pkg;

  // bt.601 full-range coefficients, scaled by 2^16
  localparam logic [15:0] KY_R = 16'd19595;
  localparam logic [15:0] KY_G = 16'd38470;
  localparam logic [15:0] KY_B = 16'd7471;
  localparam logic [15:0] K_CB = 16'd36985;
  localparam logic [15:0] K_CR = 16'd46745;
  localparam logic [16:0] K_RV = 17'd91881;
  localparam logic [16:0] K_BU = 17'd116130;
  localparam logic [16:0] K_GN = 17'd111646;
  localparam logic [23:0] CHROMA_OFS = 24'd8355840;

  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_INV = 1'b1;

  typedef struct packed {
    logic [7:0] component_a;
    logic [7:0] component_b;
    logic [7:0] component_c;
    logic       last_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_a;
    logic [7:0] result_b;
    logic [7:0] result_c;
    logic       last_out;
  } out_word_t;

  // first products
  typedef struct packed {
    logic               dir;
    logic               last;
    logic [7:0]         a;
    logic [7:0]         c;
    logic [22:0]        ya;
    logic [23:0]        yb;
    logic [20:0]        yc;
    logic signed [25:0] rv;
    logic signed [25:0] bu;
  } s1_t;

  // rounded luma, or unclamped red and blue
  typedef struct packed {
    logic              dir;
    logic              last;
    logic [7:0]        a;
    logic [7:0]        c;
    logic [7:0]        y;
    logic signed [9:0] r;
    logic signed [9:0] bl;
  } s2_t;

  // second products
  typedef struct packed {
    logic               dir;
    logic               last;
    logic [7:0]         a;
    logic [7:0]         y;
    logic signed [9:0]  r;
    logic signed [9:0]  bl;
    logic signed [24:0] pm;
    logic signed [24:0] pn;
  } s3_t;

  typedef struct packed {
    logic               dir;
    logic               last;
    logic signed [9:0]  res_a;
    logic signed [9:0]  res_c;
    logic [7:0]         res_b;
    logic signed [25:0] num;
  } s4_t;

  typedef struct packed {
    logic               dir;
    logic               last;
    logic signed [9:0]  res_a;
    logic signed [9:0]  res_c;
    logic [7:0]         res_b;
    logic signed [42:0] gp;
  } s5_t;

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic [7:0] res;
    priority if (v < 12'sd0) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/rycc_front.sv =====
// rycc_front: first two pipeline stages, coefficient products and
// rounded luma / red / blue; depends on rycc_pkg
module rycc_front
  import rycc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_vld,
  input  logic     dir,
  input  in_word_t in_word,
  output logic     s2_vld,
  output s2_t      s2
);

  s1_t  s1_nxt, s1_r;
  s2_t  s2_nxt, s2_r;
  logic s1_vld_r, s2_vld_r;

  logic signed [9:0]  cr_w, cb_w;
  logic signed [8:0]  cr_d, cb_d;
  logic [24:0]        ysum;
  logic signed [26:0] vr, vb, rsum, bsum;

  // stage 1: constant products
  always_comb begin
    cr_w = $signed({1'b0, in_word.component_c, 1'b0}) - 10'sd255;
    cb_w = $signed({1'b0, in_word.component_b, 1'b0}) - 10'sd255;
    cr_d = $signed(cr_w[8:0]);
    cb_d = $signed(cb_w[8:0]);
    s1_nxt.dir  = dir;
    s1_nxt.last = in_word.last_in;
    s1_nxt.a    = in_word.component_a;
    s1_nxt.c    = in_word.component_c;
    s1_nxt.ya   = {15'd0, in_word.component_a} * {7'd0, KY_R};
    s1_nxt.yb   = {16'd0, in_word.component_b} * {8'd0, KY_G};
    s1_nxt.yc   = {13'd0, in_word.component_c} * {5'd0, KY_B};
    s1_nxt.rv   = $signed(26'(cr_d)) * $signed({9'd0, K_RV});
    s1_nxt.bu   = $signed(26'(cb_d)) * $signed({9'd0, K_BU});
  end

  // stage 2: sum and round half away from zero
  always_comb begin
    ysum = 25'(s1_r.ya) + 25'(s1_r.yb) + 25'(s1_r.yc) + 25'd32768;
    vr   = $signed({2'b00, s1_r.a, 17'd0}) + 27'(s1_r.rv);
    vb   = $signed({2'b00, s1_r.a, 17'd0}) + 27'(s1_r.bu);
    rsum = vr + 27'sd65536 - $signed({26'd0, vr[26]});
    bsum = vb + 27'sd65536 - $signed({26'd0, vb[26]});
    s2_nxt.dir  = s1_r.dir;
    s2_nxt.last = s1_r.last;
    s2_nxt.a    = s1_r.a;
    s2_nxt.c    = s1_r.c;
    s2_nxt.y    = ysum[23:16];
    s2_nxt.r    = $signed(rsum[26:17]);
    s2_nxt.bl   = $signed(bsum[26:17]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
    end
  end

  assign s2_vld = s2_vld_r;
  assign s2     = s2_r;

endmodule

// ===== sv/rycc_chroma.sv =====
// rycc_chroma: stages 3 and 4, chroma products and rounding, or the
// green numerator in inverse mode; depends on rycc_pkg
module rycc_chroma
  import rycc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic s2_vld,
  input  s2_t  s2,
  output logic s4_vld,
  output s4_t  s4
);

  s3_t  s3_nxt, s3_r;
  s4_t  s4_nxt, s4_r;
  logic s3_vld_r, s4_vld_r;

  logic signed [8:0]  dcb, dcr;
  logic signed [24:0] cbp, crp, gb, gr;
  logic signed [25:0] vcb, vcr, cbs, crs;
  logic signed [9:0]  cb, cr;

  // stage 3
  always_comb begin
    dcb = $signed({1'b0, s2.c}) - $signed({1'b0, s2.y});
    dcr = $signed({1'b0, s2.a}) - $signed({1'b0, s2.y});
    cbp = $signed(25'(dcb)) * $signed({9'd0, K_CB});
    crp = $signed(25'(dcr)) * $signed({9'd0, K_CR});
    gb  = $signed(25'(s2.bl)) * $signed({9'd0, KY_B});
    gr  = $signed(25'(s2.r)) * $signed({9'd0, KY_R});
    s3_nxt.dir  = s2.dir;
    s3_nxt.last = s2.last;
    s3_nxt.a    = s2.a;
    s3_nxt.y    = s2.y;
    s3_nxt.r    = s2.r;
    s3_nxt.bl   = s2.bl;
    if (s2.dir == DIR_INV) begin
      s3_nxt.pm = gb;
      s3_nxt.pn = gr;
    end else begin
      s3_nxt.pm = cbp;
      s3_nxt.pn = crp;
    end
  end

  // stage 4
  always_comb begin
    vcb = 26'(s3_r.pm) + $signed({2'b00, CHROMA_OFS});
    vcr = 26'(s3_r.pn) + $signed({2'b00, CHROMA_OFS});
    cbs = vcb + 26'sd32768 - $signed({25'd0, vcb[25]});
    crs = vcr + 26'sd32768 - $signed({25'd0, vcr[25]});
    cb  = $signed(cbs[25:16]);
    cr  = $signed(crs[25:16]);
    s4_nxt.dir  = s3_r.dir;
    s4_nxt.last = s3_r.last;
    s4_nxt.num  = $signed({2'b00, s3_r.a, 16'd0}) - 26'(s3_r.pm) - 26'(s3_r.pn);
    if (s3_r.dir == DIR_INV) begin
      s4_nxt.res_a = s3_r.r;
      s4_nxt.res_b = 8'd0;
      s4_nxt.res_c = s3_r.bl;
    end else begin
      s4_nxt.res_a = $signed({2'b00, s3_r.y});
      s4_nxt.res_b = clamp8(12'(cb));
      s4_nxt.res_c = $signed({2'b00, clamp8(12'(cr))});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
    end
  end

  assign s4_vld = s4_vld_r;
  assign s4     = s4_r;

endmodule

// ===== sv/rycc_green.sv =====
// rycc_green: stage 5, scales the green numerator by 1/0.587
// depends on rycc_pkg
module rycc_green
  import rycc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic s4_vld,
  input  s4_t  s4,
  output logic s5_vld,
  output s5_t  s5
);

  s5_t  s5_nxt, s5_r;
  logic s5_vld_r;

  always_comb begin
    s5_nxt.dir   = s4.dir;
    s5_nxt.last  = s4.last;
    s5_nxt.res_a = s4.res_a;
    s5_nxt.res_b = s4.res_b;
    s5_nxt.res_c = s4.res_c;
    s5_nxt.gp    = $signed(43'(s4.num)) * $signed({26'd0, K_GN});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r <= s5_nxt;
    end
  end

  assign s5_vld = s5_vld_r;
  assign s5     = s5_r;

endmodule

// ===== sv/rgb_ycbcr_color_convert_unit.sv =====
// rgb_ycbcr_color_convert_unit: top level of the pixel color converter
// depends on rycc_pkg, rycc_front, rycc_chroma, rycc_green
//
// usage
//   input channel: in_valid / in_stall / in_word carries one pixel
//   (three 8-bit components and a last flag) per word; a word is taken
//   at a clock edge with in_valid high and in_stall low
//   output channel: out_valid / out_stall / out_word carries the
//   converted pixel, last_out copied from last_in
//   config channel: cfg_valid / cfg_ready / cfg_data writes the
//   direction bit (0 rgb to ycbcr, 1 ycbcr to rgb); cfg_ready is always
//   high, write it only while the pipe is empty
//   throughput: one pixel per clock while the pipe is not stalled, every pixel independent
//   path: an accepted word passes the six register stages (products,
//   first rounding, second products, chroma rounding or green
//   numerator, green scaling, clamp and output reg) before out_valid
//   rises with it
//   stall: the whole pipe holds while out_valid and out_stall are both
//   high; in_stall is raised in exactly those cycles, bubbles are
//   refilled whenever the output word is taken or empty
//   reset: rst_n synchronous active low, clears all valid bits and sets
//   the direction to rgb to ycbcr
module rgb_ycbcr_color_convert_unit
  import rycc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic      dir_r, dir_nxt;
  logic      en;
  logic      s2_vld, s4_vld, s5_vld;
  s2_t       s2;
  s4_t       s4;
  s5_t       s5;
  logic      out_vld_r;
  out_word_t out_nxt, out_r;

  logic signed [42:0] gsum;
  logic signed [10:0] g;

  // pipe advances unless the output word is held by the receiver
  assign en       = ~out_vld_r | ~out_stall;
  assign in_stall = ~en;
  assign cfg_ready = 1'b1;

  // direction register
  always_comb begin
    dir_nxt = dir_r;
    if (cfg_valid && cfg_ready) begin
      dir_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= DIR_FWD;
    end else begin
      dir_r <= dir_nxt;
    end
  end

  rycc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .dir     (dir_r),
    .in_word (in_word),
    .s2_vld  (s2_vld),
    .s2      (s2)
  );

  rycc_chroma u_chroma (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .s2_vld (s2_vld),
    .s2     (s2),
    .s4_vld (s4_vld),
    .s4     (s4)
  );

  rycc_green u_green (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .s4_vld (s4_vld),
    .s4     (s4),
    .s5_vld (s5_vld),
    .s5     (s5)
  );

  // final stage: round green by 2^32 (half away from zero) and clamp
  always_comb begin
    gsum = s5.gp + 43'sd2147483648 - $signed({42'd0, s5.gp[42]});
    g    = $signed(gsum[42:32]);
    out_nxt.result_a = clamp8(12'(s5.res_a));
    out_nxt.result_c = clamp8(12'(s5.res_c));
    out_nxt.last_out = s5.last;
    if (s5.dir == DIR_INV) begin
      out_nxt.result_b = clamp8(12'(g));
    end else begin
      out_nxt.result_b = s5.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

endmodule

// ===== sv/rycc_checker.sv =====
// rycc_checker: port-level checks of the color converter, bound to
// the top level; depends on rycc_pkg
module rycc_checker
  import rycc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // held output word stays valid
  a_out_hold_vld: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // held output word keeps its value
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_word))
    else $error("output word changed while stalled");

  // input backpressure only when the output is blocked
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a word accepted with the pipe moving through every stage appears at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall
      ##1 !in_stall ##1 !in_stall |=> out_valid)
    else $error("accepted word missing at output");

endmodule

bind rgb_ycbcr_color_convert_unit rycc_checker u_rycc_checker (.*);
